FILE: rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg: shared types and constants of the sliding-window rate meter
// Sample layout, pointer helpers, register indexes, reset values and the
// widths used by the bit-serial rate divider.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int SAMPLE_DEPTH = 64;
  localparam int PTR_W        = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);

  localparam int WORD_W = 32;
  localparam int SUM_W  = 64;
  localparam int HELD_W = 7;
  localparam int IN_W   = 96;
  localparam int OUT_W  = 168;
  localparam int ADDR_W = 4;

  // 1000 = 1024 - 16 - 8; sum * 1000 fits in 74 bits
  localparam int PROD_W      = 74;
  localparam int SCALE_SH_HI = 10;
  localparam int SCALE_SH_A  = 4;
  localparam int SCALE_SH_B  = 3;
  localparam int STEP_W      = $clog2(PROD_W + 1);

  localparam logic [WORD_W-1:0] WINDOW_RST   = 32'd10000;
  localparam logic [WORD_W-1:0] IDLE_GAP_RST = 32'd1000;
  localparam logic [WORD_W-1:0] MIN_AGE_RST  = 32'd2000;

  typedef enum logic [1:0] {
    REG_UPLOAD_START = 2'd0,
    REG_WINDOW       = 2'd1,
    REG_IDLE_GAP     = 2'd2,
    REG_MIN_AGE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [WORD_W-1:0] tick;
  } sample_t;

  // circular pointer advance, off must stay below SAMPLE_DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(SAMPLE_DEPTH)) begin
      s = s - (CNT_W+1)'(SAMPLE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/swrm_ram.sv
// ----------------------------------------------------------------------------
// swrm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module swrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div: bit-serial scaled rate divider
// Computes min(sum * 1000 / age, 2^32-1). The scaled sum is formed in the
// SCALE and LOAD states, then shifted out one bit per cycle through a restoring divider.
// ----------------------------------------------------------------------------
module swrm_div import swrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [WORD_W-1:0] age,
  output logic              done,
  output logic [WORD_W-1:0] rate
);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_SCALE = 4'b0010,
    D_LOAD  = 4'b0100,
    D_RUN   = 4'b1000
  } dstate_t;

  dstate_t            state;
  logic [SUM_W-1:0]   sum_r;
  logic [WORD_W-1:0]  age_r;
  logic [PROD_W-1:0]  mid;
  logic [PROD_W-1:0]  prod;
  logic [WORD_W-1:0]  rem;
  logic [WORD_W-1:0]  quo;
  logic               sat;
  logic [STEP_W-1:0]  steps;

  logic [WORD_W:0]    trial;
  logic               qbit;
  logic [WORD_W-1:0]  rem_next;

  always_comb begin
    trial = {rem, prod[PROD_W-1]};
    qbit  = (trial >= {1'b0, age_r});
    if (qbit) begin
      rem_next = WORD_W'(trial - {1'b0, age_r});
    end else begin
      rem_next = trial[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            sum_r <= sum;
            age_r <= age;
            state <= D_SCALE;
          end
        end
        D_SCALE: begin
          mid   <= (PROD_W'(sum_r) << SCALE_SH_A) + (PROD_W'(sum_r) << SCALE_SH_B);
          state <= D_LOAD;
        end
        D_LOAD: begin
          prod  <= (PROD_W'(sum_r) << SCALE_SH_HI) - mid;
          rem   <= '0;
          quo   <= '0;
          sat   <= 1'b0;
          steps <= STEP_W'(PROD_W);
          state <= D_RUN;
        end
        D_RUN: begin
          rem   <= rem_next;
          prod  <= prod << 1;
          quo   <= {quo[WORD_W-2:0], qbit};
          sat   <= sat | quo[WORD_W-1];
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rate = sat ? '1 : quo;

endmodule

FILE: rtl/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter: windowed upload throughput meter
// Keeps a FIFO of byte/tick samples and reports the rate over the window.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one update request: complete-file bytes, part-file bytes
//   and the current millisecond tick. Each update yields exactly one result
//   on m_axis: rate, window byte sum, running total and samples held.
//   The APB port sets upload start, window length, idle gap and minimum
//   upload age; write it only while no update is in flight.
// Sequence and throughput:
//   One update at a time. Each accepted update pushes a sample when needed
//   (a full FIFO first drops its oldest sample), then walks the sample RAM
//   to evict old samples (read, then check; at most 64), and, when a rate is
//   computed, runs the bit-serial divider (one quotient bit per cycle over a
//   74-bit scaled sum).
// Reset:
//   Clears the FIFO pointers, sums and output valid; registers return to
//   their defaults. The sample RAM is not cleared; only held entries are used.
// Stalls:
//   A result waits in the output register until taken; a new update may be
//   accepted meanwhile, and its result waits at the end until the slot frees.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter import swrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] complete_file_bytes, [63:32] part_file_bytes, [95:64] now_ms
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [31:0] rate_bytes_per_s, [95:32] window_bytes, [159:96] total_bytes,
  // [166:160] samples_held, [167] zero
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PUSH   = 8'b0000_0010,
    S_DROP   = 8'b0000_0100,
    S_PUSHW  = 8'b0000_1000,
    S_EVWAIT = 8'b0001_0000,
    S_EVCHK  = 8'b0010_0000,
    S_RATE   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t            state;

  logic [WORD_W-1:0] upload_start;
  logic [WORD_W-1:0] window_ms;
  logic [WORD_W-1:0] idle_gap;
  logic [WORD_W-1:0] min_upload_age;

  logic [WORD_W-1:0] now_r;
  logic [WORD_W-1:0] sent;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  window_sum;
  logic [SUM_W-1:0]  total;
  logic [WORD_W-1:0] rate_r;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [PTR_W-1:0]  ram_raddr;
  sample_t           ram_wdata;
  sample_t           rd_s;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_rate;

  logic [WORD_W:0]   in_sum;
  logic [WORD_W-1:0] in_sent;
  logic [WORD_W-1:0] gap;
  logic              push;
  logic              full;
  logic [WORD_W-1:0] age;
  logic              evict;
  logic [WORD_W-1:0] up_age;
  logic              rate_ok;
  logic              out_load;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upload_start   <= '0;
      window_ms      <= WINDOW_RST;
      idle_gap       <= IDLE_GAP_RST;
      min_upload_age <= MIN_AGE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_UPLOAD_START: upload_start   <= pwdata;
        REG_WINDOW:       window_ms      <= pwdata;
        REG_IDLE_GAP:     idle_gap       <= pwdata;
        REG_MIN_AGE:      min_upload_age <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_UPLOAD_START: prdata = upload_start;
      REG_WINDOW:       prdata = window_ms;
      REG_IDLE_GAP:     prdata = idle_gap;
      REG_MIN_AGE:      prdata = min_upload_age;
      default:          prdata = '0;
    endcase
  end

  // ---------------- sample RAM ----------------
  assign ram_waddr = ptr_add(head, count);
  assign ram_wdata = '{bytes: sent, tick: now_r};
  assign ram_we    = (state == S_PUSHW);
  // while idle, keep the newest sample ready for the idle-gap check
  assign ram_raddr = (state == S_IDLE) ? ptr_add(head, count - 1'b1) : head;

  swrm_ram #(
    .WIDTH ($bits(sample_t)),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_s)
  );

  // ---------------- datapath decisions ----------------
  always_comb begin
    in_sum  = {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]};
    in_sent = in_sum[WORD_W] ? '1 : in_sum[WORD_W-1:0];
    gap     = now_r - rd_s.tick;
    full    = (count == CNT_W'(SAMPLE_DEPTH));
    push    = (sent != '0) || (count == '0) || (gap >= idle_gap);
    age     = now_r - rd_s.tick;
    evict   = (count != '0) && (age > window_ms);
    if ((upload_start != '0) && (now_r >= upload_start)) begin
      up_age = now_r - upload_start;
    end else begin
      up_age = '0;
    end
    rate_ok   = (count != '0) && (up_age > min_upload_age) && (age != '0);
    div_start = (state == S_EVCHK) && !evict && rate_ok;
  end

  swrm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (window_sum),
    .age   (age),
    .done  (div_done),
    .rate  (div_rate)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      window_sum <= '0;
      total      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sent  <= in_sent;
            now_r <= s_axis_tdata[95:64];
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          total <= total + SUM_W'(sent);
          if (push) begin
            state <= full ? S_DROP : S_PUSHW;
          end else begin
            state <= S_EVWAIT;
          end
        end
        S_DROP: begin
          window_sum <= window_sum - SUM_W'(rd_s.bytes);
          head       <= ptr_add(head, CNT_W'(1));
          count      <= count - 1'b1;
          state      <= S_PUSHW;
        end
        S_PUSHW: begin
          window_sum <= window_sum + SUM_W'(sent);
          count      <= count + 1'b1;
          state      <= S_EVWAIT;
        end
        S_EVWAIT: begin
          state <= S_EVCHK;
        end
        S_EVCHK: begin
          if (evict) begin
            window_sum <= window_sum - SUM_W'(rd_s.bytes);
            head       <= ptr_add(head, CNT_W'(1));
            count      <= count - 1'b1;
            state      <= S_EVWAIT;
          end else if (rate_ok) begin
            state <= S_RATE;
          end else begin
            rate_r <= '0;
            state  <= S_OUT;
          end
        end
        S_RATE: begin
          if (div_done) begin
            rate_r <= div_rate;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, HELD_W'(count), total, window_sum, rate_r};
    end
  end

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SAMPLE_DEPTH))
    else $error("sample count above FIFO depth");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_evict_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVCHK) |-> ($past(state == S_EVWAIT) && $stable(head)))
    else $error("eviction check on stale RAM read");

  a_div_age: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (age != '0) && (count != '0))
    else $error("divider started with zero age or empty FIFO");

endmodule
